// ===== design/fmiq_pkg.sv =====
`default_nettype none

package fmiq_pkg;

   localparam int FRAC_BITS  = 30;
   localparam int XY_BITS    = 33;
   localparam int Z_BITS     = 34;
   localparam int MAX_STAGES = 24;

   localparam logic [0:0] REG_MOD_GAIN    = 1'd0;
   localparam logic [0:0] REG_CARRIER_INIT = 1'd1;

   localparam logic [31:0] MOD_GAIN_RESET = 32'd2670177;
   localparam logic signed [XY_BITS-1:0] X_INIT = 33'sd586829586;

   localparam logic [31:0] ATAN_TURNS [MAX_STAGES] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41721,     32'd20860,
      32'd10430,     32'd5215,      32'd2607,      32'd1303,
      32'd651,       32'd325,       32'd162,       32'd81
   };

   typedef struct packed {
      logic signed [XY_BITS-1:0] x;
      logic signed [XY_BITS-1:0] y;
      logic signed [Z_BITS-1:0]  z;
      logic                      flip;
   } cordic_type;

endpackage

`default_nettype wire

// ===== design/fm_modulator_iq.sv =====
// FM modulator with CORDIC I/Q output.
// Pipeline: product register, phase accumulator, one cell per CORDIC stage (24 at most), output register.
// Throughput: one beat per cycle while rsp_ready is high; a low rsp_ready stalls the pipeline.
// Reset: pipeline empties, mod_gain returns to 2670177 and the phase accumulator to 0.
`default_nettype none

module fm_modulator_iq #(
   parameter int PHASE_BITS    = 24,
   parameter int SAMPLE_BITS   = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire  signed [SAMPLE_BITS-1:0] req_mod_sample,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_i_out,
   output logic signed [SAMPLE_BITS-1:0] rsp_q_out,
   input  wire                          csr_we,
   input  wire         [0:0]             csr_index,
   input  wire         [PHASE_BITS-1:0]  csr_wdata
);

   localparam int NSTAGE = (CORDIC_STAGES > fmiq_pkg::MAX_STAGES) ?
                           fmiq_pkg::MAX_STAGES : CORDIC_STAGES;
   localparam int ASHIFT = 32 - PHASE_BITS;
   localparam int RSHIFT = fmiq_pkg::FRAC_BITS + 1 - SAMPLE_BITS;
   localparam int RW     = fmiq_pkg::XY_BITS + 1;
   localparam logic signed [RW-1:0] RND =
      $signed(RW'(1) << (fmiq_pkg::FRAC_BITS - SAMPLE_BITS));
   localparam logic signed [RW-1:0] SAT_HI = $signed((RW'(1) << (SAMPLE_BITS - 1)) - RW'(1));
   localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);

   logic [PHASE_BITS-1:0] gain_ff, gain_in;
   logic                  ph_valid, ph_ready;
   logic [PHASE_BITS-1:0] ph_phase;
   logic                  load;
   logic [31:0]           angle, folded;
   logic                  flip;

   logic                 vld   [NSTAGE+1];
   logic                 rdy   [NSTAGE+1];
   fmiq_pkg::cordic_type data  [NSTAGE+1];

   logic                          out_vld_ff, out_vld_in;
   logic signed [SAMPLE_BITS-1:0] i_ff, i_in, q_ff, q_in;
   logic                          out_ready;
   logic signed [fmiq_pkg::XY_BITS-1:0] xf, yf;
   logic signed [RW-1:0]          xr, yr;

   function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [RW-1:0] v);
      logic signed [RW-1:0] r;
      r = v;
      if (r > SAT_HI) begin
         r = SAT_HI;
      end else if (r < SAT_LO) begin
         r = SAT_LO;
      end
      return r[SAMPLE_BITS-1:0];
   endfunction

   always_comb begin
      gain_in = gain_ff;
      if (csr_we && (csr_index == fmiq_pkg::REG_MOD_GAIN)) begin
         gain_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= fmiq_pkg::MOD_GAIN_RESET[PHASE_BITS-1:0];
      end else begin
         gain_ff <= gain_in;
      end
   end

   assign load = csr_we && (csr_index == fmiq_pkg::REG_CARRIER_INIT);

   fmiq_phase #(
      .PHASE_BITS  (PHASE_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_phase (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_sample  (req_mod_sample),
      .gain       ($signed(gain_ff)),
      .load       (load),
      .load_phase (csr_wdata),
      .out_valid  (ph_valid),
      .out_ready  (ph_ready),
      .out_phase  (ph_phase)
   );

   // fold into [-pi/2, pi/2) by a half turn
   assign angle  = 32'(ph_phase) << ASHIFT;
   assign flip   = angle[31] ^ angle[30];
   assign folded = flip ? (angle ^ 32'h8000_0000) : angle;

   assign data[0]  = {fmiq_pkg::X_INIT, {fmiq_pkg::XY_BITS{1'b0}},
                      fmiq_pkg::Z_BITS'($signed(folded)), flip};
   assign vld[0]   = ph_valid;
   assign ph_ready = rdy[0];

   for (genvar g = 0; g < NSTAGE; g++) begin : g_cell
      fmiq_cell #(
         .IDX (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (vld[g]),
         .in_ready  (rdy[g]),
         .in_data   (data[g]),
         .out_valid (vld[g+1]),
         .out_ready (rdy[g+1]),
         .out_data  (data[g+1])
      );
   end

   assign out_ready   = !out_vld_ff || rsp_ready;
   assign rdy[NSTAGE] = out_ready;

   assign xf = data[NSTAGE].flip ? -data[NSTAGE].x : data[NSTAGE].x;
   assign yf = data[NSTAGE].flip ? -data[NSTAGE].y : data[NSTAGE].y;
   assign xr = (RW'(xf) + RND) >>> RSHIFT;
   assign yr = (RW'(yf) + RND) >>> RSHIFT;

   always_comb begin
      out_vld_in = out_vld_ff;
      i_in       = i_ff;
      q_in       = q_ff;
      if (out_ready) begin
         out_vld_in = vld[NSTAGE];
         i_in       = sat(xr);
         q_in       = sat(yr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
      i_ff <= i_in;
      q_ff <= q_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_i_out = i_ff;
   assign rsp_q_out = q_ff;

endmodule

`default_nettype wire

// ===== design/fmiq_phase.sv =====
`default_nettype none

module fmiq_phase #(
   parameter int PHASE_BITS  = 24,
   parameter int SAMPLE_BITS = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          in_valid,
   output logic                         in_ready,
   input  wire  signed [SAMPLE_BITS-1:0] in_sample,
   input  wire  signed [PHASE_BITS-1:0]  gain,
   input  wire                          load,
   input  wire         [PHASE_BITS-1:0]  load_phase,
   output logic                         out_valid,
   input  wire                          out_ready,
   output logic        [PHASE_BITS-1:0]  out_phase
);

   localparam int PROD_BITS = SAMPLE_BITS + PHASE_BITS;
   localparam logic [PROD_BITS-1:0] ROUND = PROD_BITS'(1) << (SAMPLE_BITS - 2);

   logic                        prod_vld_ff, prod_vld_in;
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   logic                        acc_vld_ff, acc_vld_in;
   logic [PHASE_BITS-1:0]       acc_ff, acc_in;
   logic [PROD_BITS-1:0]        rounded;
   logic                        acc_ready;

   assign acc_ready = !acc_vld_ff || out_ready;
   assign in_ready  = !prod_vld_ff || acc_ready;
   assign rounded   = prod_ff + ROUND;

   always_comb begin
      prod_vld_in = prod_vld_ff;
      prod_in     = prod_ff;
      acc_vld_in  = acc_vld_ff;
      acc_in      = acc_ff;
      if (acc_ready) begin
         acc_vld_in = prod_vld_ff;
         if (prod_vld_ff) begin
            acc_in = acc_ff - rounded[SAMPLE_BITS-1 +: PHASE_BITS];
         end
      end
      if (in_ready) begin
         prod_vld_in = in_valid;
         prod_in     = PROD_BITS'(in_sample) * PROD_BITS'(gain);
      end
      if (load) begin
         acc_in = load_phase;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         acc_vld_ff  <= 1'b0;
         acc_ff      <= '0;
      end else begin
         prod_vld_ff <= prod_vld_in;
         acc_vld_ff  <= acc_vld_in;
         acc_ff      <= acc_in;
      end
      prod_ff <= prod_in;
   end

   assign out_valid = acc_vld_ff;
   assign out_phase = acc_ff;

endmodule

`default_nettype wire

// ===== design/fmiq_cell.sv =====
`default_nettype none

module fmiq_cell #(
   parameter int IDX = 0
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 in_valid,
   output logic                in_ready,
   input  fmiq_pkg::cordic_type in_data,
   output logic                out_valid,
   input  wire                 out_ready,
   output fmiq_pkg::cordic_type out_data
);

   localparam logic signed [fmiq_pkg::Z_BITS-1:0] ATAN =
      $signed(fmiq_pkg::Z_BITS'(fmiq_pkg::ATAN_TURNS[IDX]));

   logic                 vld_ff, vld_in;
   fmiq_pkg::cordic_type data_ff, data_in;
   logic signed [fmiq_pkg::XY_BITS-1:0] xs, ys;

   assign in_ready = !vld_ff || out_ready;
   assign xs = in_data.x >>> IDX;
   assign ys = in_data.y >>> IDX;

   always_comb begin
      vld_in  = vld_ff;
      data_in = data_ff;
      if (in_ready) begin
         vld_in       = in_valid;
         data_in.flip = in_data.flip;
         if (!in_data.z[fmiq_pkg::Z_BITS-1]) begin
            data_in.x = in_data.x - ys;
            data_in.y = in_data.y + xs;
            data_in.z = in_data.z - ATAN;
         end else begin
            data_in.x = in_data.x + ys;
            data_in.y = in_data.y - xs;
            data_in.z = in_data.z + ATAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = vld_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== tb/fmiq_checker.sv =====
`timescale 1ns / 1ps

module fmiq_checker #(
   parameter int STAGES = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   input  wire         req_ready,
   input  wire  [15:0] req_mod_sample,
   input  wire         rsp_valid,
   input  wire         rsp_ready,
   input  wire  [15:0] rsp_i_out,
   input  wire  [15:0] rsp_q_out,
   input  wire         csr_we,
   input  wire  [0:0]  csr_index,
   input  wire  [23:0] csr_wdata,
   output int          errors,
   output int          outstanding
);

   localparam int    CORDIC_DEPTH = (STAGES > 24) ? 24 : STAGES;
   localparam longint X_START     = 64'sd586829586;

   localparam logic [31:0] ARCTAN_TURNS [24] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41721,     32'd20860,
      32'd10430,     32'd5215,      32'd2607,      32'd1303,
      32'd651,       32'd325,       32'd162,       32'd81
   };

   typedef struct {
      logic [15:0] i_val;
      logic [15:0] q_val;
   } iq_type;

   logic [23:0] gain_reg;
   logic [23:0] carrier_acc;
   iq_type      iq_expected [$];

   function automatic logic [23:0] phase_step(input logic [15:0] sample,
                                              input logic [23:0] gain);
      longint prod;
      prod = longint'($signed(sample)) * longint'($signed(gain));
      prod = (prod + 64'sd16384) >>> 15;
      return prod[23:0];
   endfunction

   function automatic logic [15:0] round_q15(input longint v);
      longint r;
      r = (v + 64'sd16384) >>> 15;
      if (r > 64'sd32767) r = 64'sd32767;
      if (r < -64'sd32768) r = -64'sd32768;
      return r[15:0];
   endfunction

   function automatic iq_type iq_of_phase(input logic [23:0] phase);
      logic [31:0] ang;
      logic        flip;
      longint      x, y, z, xs, ys;
      iq_type      r;
      ang  = {phase, 8'h00};
      flip = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
      if (flip) ang = ang - 32'h8000_0000;
      z = longint'($signed(ang));
      x = X_START;
      y = 0;
      for (int k = 0; k < CORDIC_DEPTH; k++) begin
         xs = x >>> k;
         ys = y >>> k;
         if (z >= 0) begin
            x = x - ys;
            y = y + xs;
            z = z - longint'(ARCTAN_TURNS[k]);
         end else begin
            x = x + ys;
            y = y - xs;
            z = z + longint'(ARCTAN_TURNS[k]);
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      r.i_val = round_q15(x);
      r.q_val = round_q15(y);
      return r;
   endfunction

   always @(posedge clock) begin
      iq_type      got;
      iq_type      want;
      logic [23:0] next_phase;
      int          fails;
      fails = 0;
      if (reset) begin
         gain_reg    = fmiq_pkg::MOD_GAIN_RESET[23:0];
         carrier_acc = '0;
         iq_expected.delete();
         errors     <= 0;
      end else begin
         if (csr_we) begin
            if (csr_index == fmiq_pkg::REG_MOD_GAIN) begin
               gain_reg = csr_wdata;
            end else if (csr_index == fmiq_pkg::REG_CARRIER_INIT) begin
               carrier_acc = csr_wdata;
            end
         end
         if (req_valid && req_ready) begin
            next_phase  = carrier_acc - phase_step(req_mod_sample, gain_reg);
            carrier_acc = next_phase;
            iq_expected.push_back(iq_of_phase(next_phase));
         end
         if (rsp_valid && rsp_ready) begin
            got.i_val = rsp_i_out;
            got.q_val = rsp_q_out;
            if (iq_expected.size() == 0) begin
               $error("rsp beat with no result pending: i_out %0d, q_out %0d",
                      $signed(got.i_val), $signed(got.q_val));
               fails++;
            end else begin
               want = iq_expected.pop_front();
               if (got.i_val !== want.i_val) begin
                  $error("i_out: expected %0d, got %0d",
                         $signed(want.i_val), $signed(got.i_val));
                  fails++;
               end
               if (got.q_val !== want.q_val) begin
                  $error("q_out: expected %0d, got %0d",
                         $signed(want.q_val), $signed(got.q_val));
                  fails++;
               end
            end
         end
         errors <= errors + fails;
      end
      outstanding <= iq_expected.size();
   end

endmodule

// ===== tb/tb_fm_modulator_iq.sv =====
`timescale 1ns / 1ps

module tb_fm_modulator_iq;

   localparam int STAGES = 16;
   localparam int LIMIT  = 200000;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_PERIODIC
   } stall_type;

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic signed [15:0] req_mod_sample = '0;
   logic               rsp_ready      = 1'b0;
   logic               csr_we         = 1'b0;
   logic        [0:0]  csr_index      = fmiq_pkg::REG_MOD_GAIN;
   logic        [23:0] csr_wdata      = '0;
   wire                req_ready;
   wire                rsp_valid;
   wire  signed [15:0] rsp_i_out;
   wire  signed [15:0] rsp_q_out;
   int                 errors;
   int                 outstanding;
   int                 burst_left     = 0;
   stall_type          stall_mode     = READY_ALWAYS;
   int unsigned        stall_left     = 0;

   fm_modulator_iq #(
      .PHASE_BITS(24),
      .SAMPLE_BITS(16),
      .CORDIC_STAGES(STAGES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mod_sample(req_mod_sample),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_i_out(rsp_i_out),
      .rsp_q_out(rsp_q_out),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   fmiq_checker #(
      .STAGES(STAGES)
   ) checker_i (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mod_sample(req_mod_sample),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_i_out(rsp_i_out),
      .rsp_q_out(rsp_q_out),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .errors(errors),
      .outstanding(outstanding)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(16, 96);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         READY_ALWAYS:   rsp_ready <= 1'b1;
         READY_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
         READY_SPARSE:   rsp_ready <= ($urandom_range(0, 3) == 0);
         READY_PERIODIC: rsp_ready <= (stall_left[2:0] != 3'd0);
         default:        rsp_ready <= 1'b1;
      endcase
   end

   initial begin
      repeat (LIMIT) @(posedge clock);
      $display("Regression FAIL");
      $finish;
   end

   task automatic send_beat(input logic [15:0] sample);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_mod_sample <= sample;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [0:0] index, input logic [23:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] pick_sample();
      if ($urandom_range(0, 4) == 0) begin
         case ($urandom_range(0, 4))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'h0001;
         endcase
      end
      return 16'($urandom);
   endfunction

   initial begin
      logic [15:0] sample_corners [9];
      logic [23:0] phase_corners [9];
      logic [23:0] gain_val;
      logic [23:0] phase_val;
      int          hold_at;
      sample_corners = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF,
                         16'h4000, 16'hC000, 16'h5555, 16'hAAAA};
      phase_corners  = '{24'h000000, 24'h400000, 24'h800000, 24'hC00000,
                         24'h7FFFFF, 24'h3FFFFF, 24'hBFFFFF, 24'h200000,
                         24'hFFFFFF};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (sample_corners[k]) send_beat(sample_corners[k]);
      drain();

      write_csr(fmiq_pkg::REG_MOD_GAIN, 24'h000000);
      foreach (phase_corners[k]) begin
         write_csr(fmiq_pkg::REG_CARRIER_INIT, phase_corners[k]);
         send_beat(pick_sample());
         drain();
      end

      write_csr(fmiq_pkg::REG_MOD_GAIN, 24'h800000);
      send_beat(16'h8000);
      send_beat(16'h7FFF);
      drain();
      write_csr(fmiq_pkg::REG_MOD_GAIN, 24'h7FFFFF);
      send_beat(16'h7FFF);
      send_beat(16'h8000);
      drain();

      for (int p = 0; p < 6; p++) begin
         case (p)
            0:       gain_val = 24'h7FFFFF;
            1:       gain_val = 24'h800000;
            2:       gain_val = fmiq_pkg::MOD_GAIN_RESET[23:0];
            3:       gain_val = 24'($urandom_range(0, 4095));
            default: gain_val = 24'($urandom);
         endcase
         if (p != 4) write_csr(fmiq_pkg::REG_MOD_GAIN, gain_val);
         if (p % 2 == 0) begin
            case (p)
               0:       phase_val = 24'h800000;
               2:       phase_val = 24'h7FFFFF;
               default: phase_val = 24'($urandom);
            endcase
            write_csr(fmiq_pkg::REG_CARRIER_INIT, phase_val);
         end
         hold_at = $urandom_range(10, 70);
         for (int n = 0; n < 80; n++) begin
            if (p == 3 && n == hold_at) drain();
            send_beat(pick_sample());
         end
         drain();
      end

      repeat (30) @(posedge clock);
      if (errors == 0 && outstanding == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/fmiq_pkg.sv
design/fmiq_phase.sv
design/fmiq_cell.sv
design/fm_modulator_iq.sv
tb/fmiq_checker.sv
tb/tb_fm_modulator_iq.sv
